FILE: hw/rtl/aip_pkg.sv
package aip_pkg;

   // width of the consumed-character counter, saturates at all ones
   localparam int MAX_OFFSET_BITS = 12;
   localparam int END_OFFSET_W    = 12;
   localparam int VALUE_W         = 64;
   localparam int BASE_W          = 5;
   localparam int CHAR_W          = 8;

   localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_X = 8'h78;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_X = 8'h58;

   localparam logic [BASE_W-1:0] BASE_AUTO = 5'd0;
   localparam logic [BASE_W-1:0] BASE_DEC  = 5'd10;
   localparam logic [BASE_W-1:0] BASE_HEX  = 5'd16;

   // digit code for a character that is no digit at all; never below any base
   localparam logic [BASE_W-1:0] DIGIT_NONE = 5'd31;

   typedef enum logic [1:0] {
      PHASE_IDLE   = 2'd0,
      PHASE_SKIP   = 2'd1,
      PHASE_ZERO   = 2'd2,
      PHASE_DIGITS = 2'd3
   } phase_type;

   typedef struct packed {
      logic [CHAR_W-1:0] char_code;
      logic              first_char;
      logic [BASE_W-1:0] base_request;
   } req_type;

   typedef struct packed {
      logic [VALUE_W-1:0]      parsed_value;
      logic [END_OFFSET_W-1:0] end_offset;
   } rsp_type;

   function automatic logic [BASE_W-1:0] digit_of(input logic [CHAR_W-1:0] c);
      logic [BASE_W-1:0] d;
      d = DIGIT_NONE;
      if (c >= 8'h30 && c <= 8'h39) begin
         d = BASE_W'(c - 8'h30);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         d = BASE_W'(c - 8'h61 + 8'd10);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         d = BASE_W'(c - 8'h41 + 8'd10);
      end
      return d;
   endfunction

endpackage

FILE: hw/rtl/ascii_integer_parser.sv
// channel    direction  handshake              payload
// request    in         req_valid / req_stall  req_char_code, req_first_char, req_base_request
// response   out        rsp_valid / rsp_stall  rsp_parsed_value, rsp_end_offset
//
// one character per cycle sustained while no string-ending character waits; a request sits in
// the input register, its parse step is done as it leaves, and results are registered;
// the per-character loop is a single 64 x 5 multiply-add on the held accumulator
// synchronous active-high reset idles the parser and empties both stages
// rsp_stall reaches req_stall only via a full queue: a two-entry output queue absorbs results,
// and only a string-ending character waits when that queue is full
module ascii_integer_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_char_code,
   input  logic        req_first_char,
   input  logic [4:0]  req_base_request,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_parsed_value,
   output logic [11:0] rsp_end_offset
);
   import aip_pkg::*;

   req_type req_data, stage_data;
   rsp_type result, rsp_data;
   logic    stage_valid, advance, emit, space_ok;

   // pack the request fields for the input register
   assign req_data.char_code    = req_char_code;
   assign req_data.first_char   = req_first_char;
   assign req_data.base_request = req_base_request;

   // input register: holds one character until the parser takes it
   aip_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_data    (req_data),
      .req_stall   (req_stall),
      .advance     (advance),
      .stage_valid (stage_valid),
      .stage_data  (stage_data)
   );

   // parse state: phase, base, accumulator, consumed count
   aip_core u_core (
      .clock       (clock),
      .reset       (reset),
      .stage_valid (stage_valid),
      .stage_data  (stage_data),
      .space_ok    (space_ok),
      .advance     (advance),
      .emit        (emit),
      .result      (result)
   );

   // result register with a skid entry behind it
   aip_out_queue u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (emit),
      .push_data (result),
      .space_ok  (space_ok),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_stall (rsp_stall)
   );

   assign rsp_parsed_value = rsp_data.parsed_value;
   assign rsp_end_offset   = rsp_data.end_offset;

endmodule

FILE: hw/rtl/aip_in_stage.sv
module aip_in_stage (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  aip_pkg::req_type req_data,
   output logic             req_stall,
   input  logic             advance,
   output logic             stage_valid,
   output aip_pkg::req_type stage_data
);
   import aip_pkg::*;

   logic    valid_ff, valid_in;
   req_type data_ff, data_in;
   logic    take;

   // slot frees in the cycle its request moves on
   assign req_stall = valid_ff && !advance;
   assign take      = req_valid && !req_stall;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (take) begin
         valid_in = 1'b1;
         data_in  = req_data;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign stage_valid = valid_ff;
   assign stage_data  = data_ff;

endmodule

FILE: hw/rtl/aip_core.sv
module aip_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             stage_valid,
   input  aip_pkg::req_type stage_data,
   input  logic             space_ok,
   output logic             advance,
   output logic             emit,
   output aip_pkg::rsp_type result
);
   import aip_pkg::*;

   phase_type                  phase_ff, phase_in;
   logic [BASE_W-1:0]          base_ff, base_in;
   logic [VALUE_W-1:0]         acc_ff, acc_in;
   logic [MAX_OFFSET_BITS-1:0] count_ff, count_in;

   phase_type                  cur_phase;
   logic [BASE_W-1:0]          cur_base, step_base, digit;
   logic [VALUE_W-1:0]         cur_acc, product;
   logic [MAX_OFFSET_BITS-1:0] cur_count, bumped;
   logic [VALUE_W-1:0]         count_wide;
   logic                       do_digit, stop;
   logic [CHAR_W-1:0]          c;

   // a first character restarts the string whatever state is held
   always_comb begin
      c         = stage_data.char_code;
      cur_phase = stage_data.first_char ? PHASE_SKIP : phase_ff;
      cur_base  = stage_data.first_char ? stage_data.base_request : base_ff;
      cur_acc   = stage_data.first_char ? '0 : acc_ff;
      cur_count = stage_data.first_char ? '0 : count_ff;
      bumped    = (cur_count == '1) ? cur_count : cur_count + 1'b1;
   end

   always_comb begin
      do_digit  = 1'b0;
      step_base = cur_base;
      phase_in  = cur_phase;
      base_in   = cur_base;
      count_in  = cur_count;
      case (cur_phase)
         PHASE_SKIP: begin
            if (c == CHAR_SPACE) begin
               count_in = bumped;
            end else if (cur_base == BASE_AUTO && c == CHAR_ZERO) begin
               count_in = bumped;
               phase_in = PHASE_ZERO;
            end else begin
               do_digit  = 1'b1;
               step_base = (cur_base == BASE_AUTO) ? BASE_DEC : cur_base;
            end
         end
         PHASE_ZERO: begin
            if (c == CHAR_LOWER_X || c == CHAR_UPPER_X) begin
               base_in  = BASE_HEX;
               count_in = bumped;
               phase_in = PHASE_DIGITS;
            end else begin
               do_digit  = 1'b1;
               step_base = BASE_DEC;
            end
         end
         PHASE_DIGITS: begin
            do_digit = 1'b1;
         end
         default: begin
         end
      endcase

      digit   = digit_of(c);
      stop    = do_digit && (digit >= step_base);
      product = VALUE_W'(cur_acc * {{(VALUE_W-BASE_W){1'b0}}, step_base});
      acc_in  = cur_acc;
      if (do_digit) begin
         base_in = step_base;
         if (stop) begin
            phase_in = PHASE_IDLE;
         end else begin
            phase_in = PHASE_DIGITS;
            acc_in   = product + {{(VALUE_W-BASE_W){1'b0}}, digit};
            count_in = bumped;
         end
      end
   end

   // a request that ends the string needs room in the output queue
   assign emit    = stage_valid && stop && space_ok;
   assign advance = stage_valid && (!stop || space_ok);

   assign count_wide          = VALUE_W'(cur_count);
   assign result.parsed_value = cur_acc;
   assign result.end_offset   = count_wide[END_OFFSET_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_IDLE;
         base_ff  <= '0;
         acc_ff   <= '0;
         count_ff <= '0;
      end else if (advance) begin
         phase_ff <= phase_in;
         base_ff  <= base_in;
         acc_ff   <= acc_in;
         count_ff <= count_in;
      end
   end

endmodule

FILE: hw/rtl/aip_out_queue.sv
module aip_out_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  aip_pkg::rsp_type push_data,
   output logic             space_ok,
   output logic             rsp_valid,
   output aip_pkg::rsp_type rsp_data,
   input  logic             rsp_stall
);
   import aip_pkg::*;

   logic    main_valid_ff, main_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type main_ff, main_in;
   rsp_type skid_ff, skid_in;
   logic    pop, main_kept;

   assign space_ok = !(main_valid_ff && skid_valid_ff);
   assign pop      = main_valid_ff && !rsp_stall;
   assign main_kept = main_valid_ff && !pop;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (!main_kept) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            main_valid_in = 1'b1;
            skid_in       = push_data;
            skid_valid_in = push;
         end else begin
            main_in       = push_data;
            main_valid_in = push;
            skid_valid_in = 1'b0;
         end
      end else if (!skid_valid_ff) begin
         skid_in       = push_data;
         skid_valid_in = push;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid = main_valid_ff;
   assign rsp_data  = main_ff;

endmodule
